// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk, switched off while arst_n is low
`define TWNS_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) cond) \
		else $error("assertion failed");

// Same, with a message of the caller's choosing
`define TWNS_ASSERT_MSG(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) cond) \
		else $error(msg);

`endif

// ===== hw/rtl/twns_pkg.sv =====
// Shared constants, types and codes of the wrap and nearest-texel sampler
package twns_pkg;

	// Block sizing
	localparam int MAX_SIDE     = 64;
	localparam int MAX_TEXELS   = 4096;
	localparam int CHANNEL_BITS = 16;

	// Field widths
	localparam int COORD_W   = 24;
	localparam int COEF_W    = 16;
	localparam int ROW_W     = 3 * COEF_W;
	localparam int SIZE_W    = 7;
	localparam int IDX_W     = 6;
	localparam int ADDR_W    = 12;
	localparam int TEXEL_W   = 3 * CHANNEL_BITS;
	localparam int CFG_IDX_W = 3;

	// Arithmetic widths
	localparam int FRAC_BITS = 16;
	localparam int COEF_FRAC = 12;
	localparam int PROD_W    = COEF_W + COORD_W;
	localparam int ACC_W     = PROD_W + 2;
	localparam int SHIFT_W   = ACC_W - COEF_FRAC;
	localparam int WRAP_W    = FRAC_BITS + 1;
	localparam int SCALE_W   = WRAP_W + SIZE_W;
	localparam int LIN_W     = IDX_W + SIZE_W;

	// Queue and result buffer sizing
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;
	localparam int OUT_DEPTH   = 4;
	localparam int OUT_PTR_W   = 2;
	localparam int OUT_CNT_W   = 3;
	localparam int PEND_W      = 5;

	// Constant values
	localparam logic [WRAP_W-1:0]  WRAP_ONE    = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [SIZE_W-1:0]  SIZE_ONE    = 7'd1;
	localparam logic [SIZE_W-1:0]  SIZE_MAX    = 7'(MAX_SIDE);
	localparam logic [ROW_W-1:0]   ROW_U_RESET = 48'h0000_0000_1000;
	localparam logic [ROW_W-1:0]   ROW_V_RESET = 48'h0000_1000_0000;
	localparam logic [COORD_W-1:0] COORD_MAX   = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] COORD_MIN   = {1'b1, {(COORD_W-1){1'b0}}};

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_U  = 3'd0,
		CFG_ROW_V  = 3'd1,
		CFG_WRAP   = 3'd2,
		CFG_WIDTH  = 3'd3,
		CFG_HEIGHT = 3'd4
	} cfg_reg_t;

	// Wrap modes; the unused code behaves as repeat
	typedef enum logic [1:0] {
		WRAP_REPEAT = 2'd0,
		WRAP_CLAMP  = 2'd1,
		WRAP_MIRROR = 2'd2
	} wrap_mode_t;

	// Configuration as seen by the front end, sizes already limited
	typedef struct packed {
		logic [ROW_W-1:0]  row_u;
		logic [ROW_W-1:0]  row_v;
		logic [1:0]        wrap;
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
	} cfg_t;

	// One classified item on its way to the store
	typedef struct packed {
		logic               wr;
		logic [ADDR_W-1:0]  addr;
		logic [TEXEL_W-1:0] texel;
		logic [IDX_W-1:0]   col;
		logic [IDX_W-1:0]   row;
	} job_t;

	// One result item
	typedef struct packed {
		logic [IDX_W-1:0]   col;
		logic [IDX_W-1:0]   row;
		logic [TEXEL_W-1:0] texel;
	} result_t;

endpackage

// ===== hw/rtl/texture_wrap_nearest_sampler.sv =====
// Top level: texture sampler with wrap modes and nearest-texel lookup
// A sample passes stages s1 to s3, the queue, the store read and the result buffer.
// Throughput: one item a cycle unless stalled, set by the single-port texel store RAM.
// Writes give no result and take the same path, so they stay in order with samples.
// Reset: pipeline, queue and result buffer empty; registers to defaults.
// The texel store is not cleared and holds nothing defined until written.
module texture_wrap_nearest_sampler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [twns_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [twns_pkg::ROW_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              mode,
	input  logic [twns_pkg::COORD_W-1:0]      coord_u,
	input  logic [twns_pkg::COORD_W-1:0]      coord_v,
	input  logic [twns_pkg::ADDR_W-1:0]       write_addr,
	input  logic [twns_pkg::CHANNEL_BITS-1:0] write_red,
	input  logic [twns_pkg::CHANNEL_BITS-1:0] write_green,
	input  logic [twns_pkg::CHANNEL_BITS-1:0] write_blue,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [twns_pkg::IDX_W-1:0]        texel_col,
	output logic [twns_pkg::IDX_W-1:0]        texel_row,
	output logic [twns_pkg::CHANNEL_BITS-1:0] red,
	output logic [twns_pkg::CHANNEL_BITS-1:0] green,
	output logic [twns_pkg::CHANNEL_BITS-1:0] blue
);

	twns_pkg::cfg_t    cfg;
	twns_pkg::job_t    fr_job, bk_job;
	logic              fr_valid, fr_ready, bk_valid, bk_ready;
	twns_pkg::result_t res;

	twns_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	twns_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.coord_u     (coord_u),
		.coord_v     (coord_v),
		.write_addr  (write_addr),
		.write_red   (write_red),
		.write_green (write_green),
		.write_blue  (write_blue),
		.job_valid   (fr_valid),
		.job_ready   (fr_ready),
		.job         (fr_job)
	);

	twns_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_job   (fr_job),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_job    (bk_job)
	);

	twns_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (bk_valid),
		.job_ready (bk_ready),
		.job       (bk_job),
		.res_valid (out_valid),
		.res_ready (out_ready),
		.res       (res)
	);

	// Result fields
	assign texel_col = res.col;
	assign texel_row = res.row;
	assign red       = res.texel[3*twns_pkg::CHANNEL_BITS-1:2*twns_pkg::CHANNEL_BITS];
	assign green     = res.texel[2*twns_pkg::CHANNEL_BITS-1:twns_pkg::CHANNEL_BITS];
	assign blue      = res.texel[twns_pkg::CHANNEL_BITS-1:0];

endmodule

// ===== hw/rtl/twns_ram.sv =====
// Generic single-port RAM with registered read data
module twns_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One access a cycle: write, or read into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/twns_cfg.sv =====
// Configuration registers and size limiting
module twns_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [twns_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [twns_pkg::ROW_W-1:0]       cfg_data,
	output twns_pkg::cfg_t                   cfg
);

	logic [twns_pkg::ROW_W-1:0]  row_u_q;
	logic [twns_pkg::ROW_W-1:0]  row_v_q;
	logic [1:0]                  wrap_q;
	logic [twns_pkg::SIZE_W-1:0] width_q;
	logic [twns_pkg::SIZE_W-1:0] height_q;

	// Writes are always accepted
	assign cfg_ready = 1'b1;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_u_q  <= twns_pkg::ROW_U_RESET;
			row_v_q  <= twns_pkg::ROW_V_RESET;
			wrap_q   <= twns_pkg::WRAP_REPEAT;
			width_q  <= twns_pkg::SIZE_MAX;
			height_q <= twns_pkg::SIZE_MAX;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				twns_pkg::CFG_ROW_U:  row_u_q  <= cfg_data;
				twns_pkg::CFG_ROW_V:  row_v_q  <= cfg_data;
				twns_pkg::CFG_WRAP:   wrap_q   <= cfg_data[1:0];
				twns_pkg::CFG_WIDTH:  width_q  <= cfg_data[twns_pkg::SIZE_W-1:0];
				twns_pkg::CFG_HEIGHT: height_q <= cfg_data[twns_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Zero acts as one, oversize acts as the largest side
	always_comb begin
		cfg.row_u = row_u_q;
		cfg.row_v = row_v_q;
		cfg.wrap  = wrap_q;
		if (width_q == '0) begin
			cfg.width = twns_pkg::SIZE_ONE;
		end else if (width_q > twns_pkg::SIZE_MAX) begin
			cfg.width = twns_pkg::SIZE_MAX;
		end else begin
			cfg.width = width_q;
		end
		if (height_q == '0) begin
			cfg.height = twns_pkg::SIZE_ONE;
		end else if (height_q > twns_pkg::SIZE_MAX) begin
			cfg.height = twns_pkg::SIZE_MAX;
		end else begin
			cfg.height = height_q;
		end
	end

endmodule

// ===== hw/rtl/twns_front.sv =====
// Front end: affine transform, wrap, scaling and address forming
module twns_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  twns_pkg::cfg_t                    cfg,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              mode,
	input  logic [twns_pkg::COORD_W-1:0]      coord_u,
	input  logic [twns_pkg::COORD_W-1:0]      coord_v,
	input  logic [twns_pkg::ADDR_W-1:0]       write_addr,
	input  logic [twns_pkg::CHANNEL_BITS-1:0] write_red,
	input  logic [twns_pkg::CHANNEL_BITS-1:0] write_green,
	input  logic [twns_pkg::CHANNEL_BITS-1:0] write_blue,
	output logic                              job_valid,
	input  logic                              job_ready,
	output twns_pkg::job_t                    job
);

	// Floor of acc / 2^12, saturated to signed Q8.16
	function automatic logic [twns_pkg::COORD_W-1:0] saturate(
		input logic [twns_pkg::ACC_W-1:0] acc
	);
		logic [twns_pkg::SHIFT_W-1:0] r;
		logic                         ok;
		r  = acc[twns_pkg::ACC_W-1:twns_pkg::COEF_FRAC];
		ok = (r[twns_pkg::SHIFT_W-1:twns_pkg::COORD_W-1]
			== {(twns_pkg::SHIFT_W-twns_pkg::COORD_W+1){r[twns_pkg::SHIFT_W-1]}});
		if (ok) begin
			saturate = r[twns_pkg::COORD_W-1:0];
		end else if (r[twns_pkg::SHIFT_W-1]) begin
			saturate = twns_pkg::COORD_MIN;
		end else begin
			saturate = twns_pkg::COORD_MAX;
		end
	endfunction

	// Wrapped position in [0,1] as unsigned Q1.16
	function automatic logic [twns_pkg::WRAP_W-1:0] wrap_pos(
		input logic [twns_pkg::COORD_W-1:0] t,
		input logic [1:0]                   sel
	);
		logic [twns_pkg::WRAP_W-1:0] frac;
		frac = {1'b0, t[twns_pkg::FRAC_BITS-1:0]};
		unique case (sel)
			twns_pkg::WRAP_CLAMP: begin
				if (t[twns_pkg::COORD_W-1]) begin
					wrap_pos = '0;
				end else if (t[twns_pkg::COORD_W-2:twns_pkg::FRAC_BITS] != '0) begin
					wrap_pos = twns_pkg::WRAP_ONE;
				end else begin
					wrap_pos = frac;
				end
			end
			twns_pkg::WRAP_MIRROR: begin
				// Odd period, negative ones too, runs backwards
				if (t[twns_pkg::FRAC_BITS]) begin
					wrap_pos = twns_pkg::WRAP_ONE - frac;
				end else begin
					wrap_pos = frac;
				end
			end
			default: wrap_pos = frac;
		endcase
	endfunction

	// Texel index from position and size, the top end held at size-1
	function automatic logic [twns_pkg::IDX_W-1:0] scale(
		input logic [twns_pkg::WRAP_W-1:0] w,
		input logic [twns_pkg::SIZE_W-1:0] size
	);
		logic [twns_pkg::SCALE_W-1:0] prod;
		logic [twns_pkg::SIZE_W:0]    whole;
		logic [twns_pkg::SIZE_W-1:0]  last;
		prod  = {{twns_pkg::SIZE_W{1'b0}}, w}
			* {{twns_pkg::WRAP_W{1'b0}}, size};
		whole = prod[twns_pkg::SCALE_W-1:twns_pkg::FRAC_BITS];
		last  = size - twns_pkg::SIZE_ONE;
		if (whole >= {1'b0, size}) begin
			scale = last[twns_pkg::IDX_W-1:0];
		end else begin
			scale = whole[twns_pkg::IDX_W-1:0];
		end
	endfunction

	logic                               adv;
	logic                               v_s1, v_s2, v_s3;
	logic                               wr_s1, wr_s2, wr_s3;
	logic [twns_pkg::ADDR_W-1:0]        waddr_s1, waddr_s2, waddr_s3;
	logic [twns_pkg::TEXEL_W-1:0]       texel_s1, texel_s2, texel_s3;
	logic signed [twns_pkg::PROD_W-1:0] pu_a, pu_b, pv_a, pv_b;
	logic signed [twns_pkg::PROD_W-1:0] pu_a_s1, pu_b_s1, pv_a_s1, pv_b_s1;
	logic [twns_pkg::ACC_W-1:0]         acc_u, acc_v, off_u, off_v;
	logic [twns_pkg::COORD_W-1:0]       tu_s2, tv_s2;
	logic [twns_pkg::IDX_W-1:0]         col_s3, row_s3;
	logic [twns_pkg::LIN_W-1:0]         lin_addr;

	// Whole pipeline moves unless the last stage is blocked by the queue
	assign adv      = !v_s3 || job_ready;
	assign in_ready = adv;

	// Stage 1 products
	assign pu_a = $signed(cfg.row_u[15:0])  * $signed(coord_u);
	assign pu_b = $signed(cfg.row_u[31:16]) * $signed(coord_v);
	assign pv_a = $signed(cfg.row_v[15:0])  * $signed(coord_u);
	assign pv_b = $signed(cfg.row_v[31:16]) * $signed(coord_v);

	// Stage 2 sums, offset sits at bit 16 of the Q.28 sum
	assign off_u = {{(twns_pkg::ACC_W-twns_pkg::COEF_W-twns_pkg::FRAC_BITS){cfg.row_u[47]}},
		cfg.row_u[47:32], {twns_pkg::FRAC_BITS{1'b0}}};
	assign off_v = {{(twns_pkg::ACC_W-twns_pkg::COEF_W-twns_pkg::FRAC_BITS){cfg.row_v[47]}},
		cfg.row_v[47:32], {twns_pkg::FRAC_BITS{1'b0}}};
	assign acc_u = {{2{pu_a_s1[twns_pkg::PROD_W-1]}}, pu_a_s1}
		+ {{2{pu_b_s1[twns_pkg::PROD_W-1]}}, pu_b_s1} + off_u;
	assign acc_v = {{2{pv_a_s1[twns_pkg::PROD_W-1]}}, pv_a_s1}
		+ {{2{pv_b_s1[twns_pkg::PROD_W-1]}}, pv_b_s1} + off_v;

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			wr_s1    <= mode;
			waddr_s1 <= write_addr;
			texel_s1 <= {write_red, write_green, write_blue};
			pu_a_s1  <= pu_a;
			pu_b_s1  <= pu_b;
			pv_a_s1  <= pv_a;
			pv_b_s1  <= pv_b;

			wr_s2    <= wr_s1;
			waddr_s2 <= waddr_s1;
			texel_s2 <= texel_s1;
			tu_s2    <= saturate(acc_u);
			tv_s2    <= saturate(acc_v);

			wr_s3    <= wr_s2;
			waddr_s3 <= waddr_s2;
			texel_s3 <= texel_s2;
			col_s3   <= scale(wrap_pos(tu_s2, cfg.wrap), cfg.width);
			row_s3   <= scale(wrap_pos(tv_s2, cfg.wrap), cfg.height);
		end
	end

	// Store address: row*width+column for samples, given address for writes
	assign lin_addr = {{twns_pkg::SIZE_W{1'b0}}, row_s3}
		* {{twns_pkg::IDX_W{1'b0}}, cfg.width}
		+ {{twns_pkg::SIZE_W{1'b0}}, col_s3};

	assign job_valid = v_s3;
	assign job.wr    = wr_s3;
	assign job.addr  = wr_s3 ? waddr_s3 : lin_addr[twns_pkg::ADDR_W-1:0];
	assign job.texel = texel_s3;
	assign job.col   = col_s3;
	assign job.row   = row_s3;

endmodule

// ===== hw/rtl/twns_queue.sv =====
// Short queue of classified items between front and back end
module twns_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  twns_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output twns_pkg::job_t pop_job
);

	twns_pkg::job_t                   entry_q [twns_pkg::QUEUE_DEPTH];
	logic [twns_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [twns_pkg::QUEUE_CNT_W-1:0] cnt_q;
	logic                             push, pop;

	assign push_ready = (cnt_q != twns_pkg::QUEUE_CNT_W'(twns_pkg::QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_job    = entry_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ===== hw/rtl/twns_back.sv =====
// Back end: texel store access and result buffer
module twns_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  twns_pkg::job_t job,
	output logic           res_valid,
	input  logic           res_ready,
	output twns_pkg::result_t res
);

	logic                               pop;
	logic [twns_pkg::OUT_CNT_W-1:0]     slots;
	logic                               rd_v_q;
	logic [twns_pkg::IDX_W-1:0]         rd_col_q, rd_row_q;
	logic [twns_pkg::TEXEL_W-1:0]       rdata;
	twns_pkg::result_t                  buf_q [twns_pkg::OUT_DEPTH];
	logic [twns_pkg::OUT_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [twns_pkg::OUT_CNT_W-1:0]     cnt_q;
	logic                               res_xfer;

	// A read is only issued when the buffer has room for its result
	assign slots     = cnt_q + {{(twns_pkg::OUT_CNT_W-1){1'b0}}, rd_v_q};
	assign pop       = job_valid
		&& (job.wr || slots < twns_pkg::OUT_CNT_W'(twns_pkg::OUT_DEPTH));
	assign job_ready = pop;

	twns_ram #(
		.WIDTH(twns_pkg::TEXEL_W),
		.DEPTH(twns_pkg::MAX_TEXELS)
	) u_store (
		.clk   (clk),
		.en    (pop),
		.we    (job.wr),
		.addr  (job.addr),
		.wdata (job.texel),
		.rdata (rdata)
	);

	// Read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_q <= 1'b0;
		end else begin
			rd_v_q <= pop && !job.wr;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rd_col_q <= job.col;
			rd_row_q <= job.row;
		end
	end

	// Result buffer
	assign res_valid = (cnt_q != '0);
	assign res_xfer  = res_valid && res_ready;
	assign res       = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (rd_v_q) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (res_xfer) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (rd_v_q && !res_xfer) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (res_xfer && !rd_v_q) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_v_q) begin
			buf_q[wr_ptr_q] <= '{col: rd_col_q, row: rd_row_q, texel: rdata};
		end
	end

endmodule

// ===== hw/rtl/twns_checker.sv =====
// Port-level checker for the sampler, bound to the top level
`include "assert_macros.svh"

module twns_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic [twns_pkg::CFG_IDX_W-1:0]    cfg_index,
	input logic [twns_pkg::ROW_W-1:0]        cfg_data,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              mode,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [twns_pkg::IDX_W-1:0]        texel_col,
	input logic [twns_pkg::IDX_W-1:0]        texel_row,
	input logic [twns_pkg::CHANNEL_BITS-1:0] red,
	input logic [twns_pkg::CHANNEL_BITS-1:0] green,
	input logic [twns_pkg::CHANNEL_BITS-1:0] blue
);

	logic [twns_pkg::PEND_W-1:0] pend_q;
	logic [twns_pkg::SIZE_W-1:0] width_q, height_q, eff_w, eff_h;
	logic                        smp_xfer, res_xfer;
	logic [2*twns_pkg::IDX_W+twns_pkg::TEXEL_W-1:0] res_bits;

	assign smp_xfer = in_valid && in_ready && !mode;
	assign res_xfer = out_valid && out_ready;
	assign res_bits = {texel_col, texel_row, red, green, blue};

	// Samples taken but not yet answered, and the texture size in force
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= '0;
			width_q  <= twns_pkg::SIZE_MAX;
			height_q <= twns_pkg::SIZE_MAX;
		end else begin
			if (smp_xfer && !res_xfer) begin
				pend_q <= pend_q + 1'b1;
			end else if (res_xfer && !smp_xfer) begin
				pend_q <= pend_q - 1'b1;
			end
			if (cfg_valid && cfg_ready && cfg_index == twns_pkg::CFG_WIDTH) begin
				width_q <= cfg_data[twns_pkg::SIZE_W-1:0];
			end
			if (cfg_valid && cfg_ready && cfg_index == twns_pkg::CFG_HEIGHT) begin
				height_q <= cfg_data[twns_pkg::SIZE_W-1:0];
			end
		end
	end

	always_comb begin
		eff_w = (width_q == '0) ? twns_pkg::SIZE_ONE
			: (width_q > twns_pkg::SIZE_MAX) ? twns_pkg::SIZE_MAX : width_q;
		eff_h = (height_q == '0) ? twns_pkg::SIZE_ONE
			: (height_q > twns_pkg::SIZE_MAX) ? twns_pkg::SIZE_MAX : height_q;
	end

	// Every result answers an earlier sample; writes never produce one
	`TWNS_ASSERT_MSG(a_no_spurious, out_valid |-> pend_q != '0, "result without sample")

	// A stalled result keeps its value
	`TWNS_ASSERT(a_res_hold, out_valid && !out_ready |=> out_valid && $stable(res_bits))

	// Selected texel lies inside the texture
	`TWNS_ASSERT_MSG(a_col_range, out_valid |-> {1'b0, texel_col} < eff_w, "column out of range")
	`TWNS_ASSERT_MSG(a_row_range, out_valid |-> {1'b0, texel_row} < eff_h, "row out of range")

endmodule

bind texture_wrap_nearest_sampler twns_checker u_twns_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.mode      (mode),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.texel_col (texel_col),
	.texel_row (texel_row),
	.red       (red),
	.green     (green),
	.blue      (blue)
);
